@@ rtl/core/csw_pkg.sv @@
// Shared constants for the Caesar shift word reverser.
package csw_pkg;

  // Field widths of the input, output and configuration beats.
  localparam int unsigned CharInW  = 8;
  localparam int unsigned CharOutW = 7;
  localparam int unsigned ShiftW   = 5;
  localparam int unsigned LetterW  = 5;

  // Default word buffer depth.
  localparam int unsigned MaxWordDef = 30;

  // Alphabet size for the rotation.
  localparam logic [ShiftW:0] Alphabet = 6'd26;

  // Character codes.
  localparam logic [CharInW-1:0] CharA       = 8'h41;
  localparam logic [CharInW-1:0] CharZ       = 8'h5A;
  localparam logic [CharInW-1:0] CharSpace   = 8'h20;
  localparam logic [CharInW-1:0] CharComma   = 8'h2C;
  localparam logic [CharInW-1:0] CharPeriod  = 8'h2E;
  localparam logic [CharInW-1:0] CharQuest   = 8'h3F;
  localparam logic [CharInW-1:0] CharNewline = 8'h0A;

endpackage

@@ rtl/core/csw_in_if.sv @@
// Input channel of the Caesar shift word reverser: one raw byte per beat.
interface csw_in_if;
  import csw_pkg::*;

  logic               valid;
  logic               ready;
  logic [CharInW-1:0] char_in;
  logic               end_of_text;

  modport source (output valid, output char_in, output end_of_text, input ready);
  modport sink   (input valid, input char_in, input end_of_text, output ready);
endinterface

@@ rtl/core/csw_out_if.sv @@
// Output channel of the Caesar shift word reverser: one character per beat.
interface csw_out_if;
  import csw_pkg::*;

  logic                valid;
  logic                ready;
  logic [CharOutW-1:0] char_out;
  logic                last_of_run;
  logic                overflow_error;

  modport source (output valid, output char_out, output last_of_run,
                  output overflow_error, input ready);
  modport sink   (input valid, input char_out, input last_of_run,
                  input overflow_error, output ready);
endinterface

@@ rtl/core/caesar_shift_word_reverser.sv @@
// Top level of the Caesar shift word reverser with its word buffer memory.
//
//   Channel   Direction  Handshake        Beat contents
//   in_i      sink       valid / ready    char_in, end_of_text
//   out_o     source     valid / ready    char_out, last_of_run, overflow_error
//   shift     write      shift_we_i       shift_wdata_i
//
// A letter, a dropped byte or a delimiter with no held word is handled in the idle state.
// Each held letter is read through the buffer memory read port in S_READ, then
// loaded into the output register in S_EMIT; a trailing delimiter follows in S_DELIM.
// Reset clears the word count, the halt flag and the shift register at once.
// A stalled output holds its beat; input is taken only when the output
// register is free or being emptied in the same cycle.
module caesar_shift_word_reverser #(
  parameter int unsigned MAX_WORD = csw_pkg::MaxWordDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        shift_we_i,
  input  logic [csw_pkg::ShiftW-1:0]  shift_wdata_i,
  csw_in_if.sink                      in_i,
  csw_out_if.source                   out_o
);
  import csw_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_WORD + 1);
  localparam int unsigned IdxW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;
  localparam logic [1:0] S_DELIM = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                halted_q, halted_d;
  logic [ShiftW-1:0]   shift_q;
  logic                delim_pend_q, delim_pend_d;
  logic [CharOutW-1:0] delim_q, delim_d;

  logic                out_valid_q, out_valid_d;
  logic [CharOutW-1:0] out_char_q, out_char_d;
  logic                out_last_q, out_last_d;
  logic                out_err_q, out_err_d;

  logic [LetterW-1:0]  mem_q [MAX_WORD];
  logic [LetterW-1:0]  rdata_q;
  logic                mem_we, mem_re;
  logic [IdxW-1:0]     mem_waddr, mem_raddr;
  logic [LetterW-1:0]  mem_wdata;

  logic                slot_free, in_fire;
  logic                is_letter, is_delim;
  logic [CharInW-1:0]  letter_diff;
  logic [ShiftW-1:0]   shift_mod;
  logic [ShiftW:0]     rot_sum;
  logic [ShiftW:0]     rot_red;

  // Shift register, loaded on every write enable.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
    end else if (shift_we_i) begin
      shift_q <= shift_wdata_i;
    end
  end

  // Character classes and the rotated letter index.
  assign is_letter   = (in_i.char_in >= CharA) && (in_i.char_in <= CharZ);
  assign is_delim    = in_i.char_in inside {CharSpace, CharComma, CharPeriod,
                                            CharQuest, CharNewline};
  assign letter_diff = in_i.char_in - CharA;
  assign shift_mod   = ({1'b0, shift_q} >= Alphabet) ?
                       ShiftW'({1'b0, shift_q} - Alphabet) : shift_q;
  assign rot_sum     = {1'b0, letter_diff[LetterW-1:0]} + {1'b0, shift_mod};
  assign rot_red     = (rot_sum >= Alphabet) ? (rot_sum - Alphabet) : rot_sum;

  assign slot_free   = !out_valid_q || out_o.ready;
  assign in_i.ready  = (state_q == S_IDLE) && slot_free;
  assign in_fire     = in_i.valid && in_i.ready;

  // Sequencer: store letters, then read the word back last letter first.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    halted_d     = halted_q;
    delim_pend_d = delim_pend_q;
    delim_d      = delim_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_char_d   = out_char_q;
    out_last_d   = out_last_q;
    out_err_d    = out_err_q;
    mem_we       = 1'b0;
    mem_waddr    = count_q[IdxW-1:0];
    mem_wdata    = rot_red[LetterW-1:0];
    mem_re       = 1'b0;
    mem_raddr    = IdxW'(count_q - CntW'(1));

    case (state_q)
      S_IDLE: begin
        if (in_fire && !halted_q) begin
          delim_d = in_i.char_in[CharOutW-1:0];
          if (is_letter) begin
            if (count_q >= CntW'(MAX_WORD)) begin
              // Word too long: one error beat, then halt until reset.
              count_d     = '0;
              halted_d    = 1'b1;
              out_valid_d = 1'b1;
              out_char_d  = '0;
              out_last_d  = 1'b1;
              out_err_d   = 1'b1;
            end else begin
              mem_we       = 1'b1;
              count_d      = count_q + CntW'(1);
              delim_pend_d = 1'b0;
              if (in_i.end_of_text) begin
                state_d = S_READ;
              end
            end
          end else if (is_delim) begin
            if (count_q == '0) begin
              out_valid_d = 1'b1;
              out_char_d  = in_i.char_in[CharOutW-1:0];
              out_last_d  = 1'b1;
              out_err_d   = 1'b0;
            end else begin
              delim_pend_d = 1'b1;
              state_d      = S_READ;
            end
          end else if (in_i.end_of_text && (count_q != '0)) begin
            delim_pend_d = 1'b0;
            state_d      = S_READ;
          end
        end
      end
      S_READ: begin
        mem_re  = 1'b1;
        count_d = count_q - CntW'(1);
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = CharA[CharOutW-1:0] + CharOutW'(rdata_q);
          out_last_d  = (count_q == '0) && !delim_pend_q;
          out_err_d   = 1'b0;
          if (count_q != '0) begin
            state_d = S_READ;
          end else if (delim_pend_q) begin
            state_d = S_DELIM;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_DELIM: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = delim_q;
          out_last_d  = 1'b1;
          out_err_d   = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      halted_q     <= 1'b0;
      delim_pend_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      halted_q     <= halted_d;
      delim_pend_q <= delim_pend_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    delim_q    <= delim_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    out_err_q  <= out_err_d;
  end

  // Word buffer memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // Output beat.
  assign out_o.valid          = out_valid_q;
  assign out_o.char_out       = out_char_q;
  assign out_o.last_of_run    = out_last_q;
  assign out_o.overflow_error = out_err_q;

endmodule

@@ rtl/core/csw_checker.sv @@
// Port-level checks for the Caesar shift word reverser and their bind.
module csw_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [csw_pkg::CharOutW-1:0] out_char_i,
  input logic                         out_last_i,
  input logic                         out_err_i
);
  import csw_pkg::*;

  // A stalled output beat keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_char_i)
      && $stable(out_last_i) && $stable(out_err_i))
    else $error("output beat changed while stalled");

  // An input beat is taken beside a held output beat only when that beat leaves.
  a_in_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && out_valid_i |-> out_ready_i)
    else $error("input taken while the output register was stalled");

  // The error beat is always the last beat of its run and carries a zero code.
  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_err_i |-> out_last_i && (out_char_i == '0))
    else $error("malformed overflow beat");

  // Once the error beat is taken, nothing more comes out.
  a_err_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_err_i |=> !out_valid_i)
    else $error("output after overflow");

  // A normal beat is a capital letter or a delimiter.
  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_err_i |->
      ((out_char_i >= CharA[CharOutW-1:0]) && (out_char_i <= CharZ[CharOutW-1:0]))
      || (out_char_i == CharSpace[CharOutW-1:0])
      || (out_char_i == CharComma[CharOutW-1:0])
      || (out_char_i == CharPeriod[CharOutW-1:0])
      || (out_char_i == CharQuest[CharOutW-1:0])
      || (out_char_i == CharNewline[CharOutW-1:0]))
    else $error("unexpected output character");

endmodule

bind caesar_shift_word_reverser csw_checker u_csw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_char_i  (out_o.char_out),
  .out_last_i  (out_o.last_of_run),
  .out_err_i   (out_o.overflow_error)
);

@@ sim/csw_scoreboard.sv @@
// Scoreboard for the Caesar shift word reverser: predicts and checks every output beat.
module csw_scoreboard (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       shift_we_i,
  input  logic [csw_pkg::ShiftW-1:0] shift_wdata_i,
  csw_in_if                          in_ch_i,
  csw_out_if                         out_ch_i,
  output int                         chars_owed_o,
  output int                         mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import csw_pkg::*;

  typedef struct packed {
    logic [CharOutW-1:0] char_out;
    logic                last_of_run;
    logic                overflow_error;
  } char_beat_t;

  // Shadow copy of the block state.
  logic [LetterW-1:0] held_letters [MaxWordDef];
  int                 held_count;
  logic               halted;
  logic [ShiftW-1:0]  shift_amt;

  // Output beats the block still owes, oldest first.
  char_beat_t pending_chars [$];

  task automatic push_beat(input logic [CharOutW-1:0] ch, input logic last,
                           input logic err);
    char_beat_t beat;
    beat.char_out       = ch;
    beat.last_of_run    = last;
    beat.overflow_error = err;
    pending_chars.push_back(beat);
  endtask

  // Emits the held word last letter first; mark_last tags its final letter.
  task automatic flush_word(input logic mark_last);
    while (held_count > 0) begin
      held_count--;
      push_beat(CharOutW'(int'(CharA) + int'(held_letters[held_count])),
                mark_last && (held_count == 0), 1'b0);
    end
  endtask

  // Works out the beats that one accepted input byte causes.
  task automatic encipher_byte(input logic [CharInW-1:0] c, input logic eot);
    logic is_break;
    is_break = (c == CharSpace) || (c == CharComma) || (c == CharPeriod) ||
               (c == CharQuest) || (c == CharNewline);
    if (halted) return;
    if (c >= CharA && c <= CharZ) begin
      if (held_count >= MaxWordDef) begin
        // Word too long: one error beat, then nothing until reset.
        held_count = 0;
        halted     = 1'b1;
        push_beat('0, 1'b1, 1'b1);
      end else begin
        held_letters[held_count] =
          LetterW'((int'(c - CharA) + int'(shift_amt) % int'(Alphabet)) % int'(Alphabet));
        held_count++;
        if (eot) flush_word(1'b1);
      end
    end else if (is_break) begin
      flush_word(1'b0);
      push_beat(c[CharOutW-1:0], 1'b1, 1'b0);
    end else if (eot) begin
      // A dropped byte still flushes the word at end of text.
      flush_word(1'b1);
    end
  endtask

  // Track configuration, compare output beats and predict from input beats.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    char_beat_t seen;
    char_beat_t want;
    if (!rst_ni) begin
      held_count   = 0;
      halted       = 1'b0;
      shift_amt    = '0;
      mismatches_o = 0;
      pending_chars.delete();
    end else begin
      if (shift_we_i) shift_amt = shift_wdata_i;
      if (out_ch_i.valid && out_ch_i.ready) begin
        seen.char_out       = out_ch_i.char_out;
        seen.last_of_run    = out_ch_i.last_of_run;
        seen.overflow_error = out_ch_i.overflow_error;
        if (pending_chars.size() == 0) begin
          $display("%0t ns: unexpected beat, expected none, actual ch=%h last=%b err=%b",
                   $time, seen.char_out, seen.last_of_run, seen.overflow_error);
          mismatches_o++;
        end else begin
          want = pending_chars.pop_front();
          if (seen.char_out !== want.char_out || seen.last_of_run !== want.last_of_run ||
              seen.overflow_error !== want.overflow_error) begin
            $display("%0t ns: expected ch=%h last=%b err=%b, actual ch=%h last=%b err=%b",
                     $time, want.char_out, want.last_of_run, want.overflow_error,
                     seen.char_out, seen.last_of_run, seen.overflow_error);
            mismatches_o++;
          end
        end
      end
      if (in_ch_i.valid && in_ch_i.ready) encipher_byte(in_ch_i.char_in, in_ch_i.end_of_text);
    end
    chars_owed_o = pending_chars.size();
  end

endmodule

@@ sim/caesar_shift_word_reverser_tb.sv @@
// Testbench top for the Caesar shift word reverser: stimulus, output pacing and verdict.
module caesar_shift_word_reverser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import csw_pkg::*;

  // Dropped byte values used in the opening sequence.
  localparam logic [CharInW-1:0] ByteNul     = 8'h00;
  localparam logic [CharInW-1:0] ByteAt      = 8'h40;
  localparam logic [CharInW-1:0] ByteBracket = 8'h5B;
  localparam logic [CharInW-1:0] ByteLowA    = 8'h61;
  localparam logic [CharInW-1:0] ByteLowZ    = 8'h7A;
  localparam logic [CharInW-1:0] ByteDigit   = 8'h30;
  localparam logic [CharInW-1:0] ByteDel     = 8'h7F;
  localparam logic [CharInW-1:0] ByteHigh    = 8'h80;
  localparam logic [CharInW-1:0] ByteMax     = 8'hFF;

  localparam int SettleCycles = 8;
  localparam int TailCycles   = 2 * MaxWordDef + 4;
  localparam int LongHold     = 300;
  localparam int StallLimit   = 2000;
  localparam int PhaseBeats   = 30;
  localparam int NumPhases    = 8;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              shift_we;
  logic [ShiftW-1:0] shift_wdata;
  int                chars_owed;
  int                mismatches;

  // Shared pacing controls between stimulus and the output side.
  bit idle_en       = 1'b1;
  bit hold_out_req  = 1'b0;

  logic [CharInW-1:0] word_breaks [5] = '{CharSpace, CharComma, CharPeriod, CharQuest,
                                          CharNewline};
  logic [ShiftW-1:0]  shift_plan [6]  = '{5'd0, 5'd26, 5'd25, 5'd31, 5'd1, 5'd13};

  csw_in_if  in_ch ();
  csw_out_if out_ch ();

  caesar_shift_word_reverser dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .shift_we_i    (shift_we),
    .shift_wdata_i (shift_wdata),
    .in_i          (in_ch),
    .out_o         (out_ch)
  );

  csw_scoreboard scoreboard (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .shift_we_i    (shift_we),
    .shift_wdata_i (shift_wdata),
    .in_ch_i       (in_ch),
    .out_ch_i      (out_ch),
    .chars_owed_o  (chars_owed),
    .mismatches_o  (mismatches)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [CharInW-1:0] random_letter();
    return CharA + CharInW'($urandom_range(0, int'(Alphabet) - 1));
  endfunction

  // Any byte the block drops: a kept byte gets bit 7 flipped.
  function automatic logic [CharInW-1:0] noise_byte();
    logic [CharInW-1:0] b;
    b = CharInW'($urandom_range(0, 255));
    if ((b >= CharA && b <= CharZ) || b == CharSpace || b == CharComma ||
        b == CharPeriod || b == CharQuest || b == CharNewline) b = b ^ ByteHigh;
    return b;
  endfunction

  // Offers one beat, with an occasional gap first, and waits for its acceptance.
  task automatic send_byte(input logic [CharInW-1:0] b, input logic eot);
    @(negedge clk);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.char_in     <= b;
    in_ch.end_of_text <= eot;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stops offering and waits until every owed beat has come and the block is quiet.
  task automatic drain_block();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (chars_owed == 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic load_shift(input logic [ShiftW-1:0] amount);
    drain_block();
    @(negedge clk);
    shift_we    <= 1'b1;
    shift_wdata <= amount;
    @(negedge clk);
    shift_we    <= 1'b0;
  endtask

  // Random text: words of random letters with stray bytes, each closed by a
  // delimiter, by end of text on its last letter, or by a dropped byte at end of text.
  task automatic send_text(input int n_beats);
    int sent;
    int len;
    int pick;
    sent = 0;
    while (sent < n_beats) begin
      len  = ($urandom_range(0, 11) == 0) ? MaxWordDef : $urandom_range(0, 8);
      pick = $urandom_range(0, 19);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) send_byte(noise_byte(), 1'b0);
        send_byte(random_letter(), (i == len - 1) && (pick >= 16) && (pick <= 17));
      end
      if (pick < 16) begin
        send_byte(word_breaks[$urandom_range(0, 4)], pick == 0);
      end else if (pick > 17 || len == 0) begin
        send_byte(noise_byte(), 1'b1);
      end
      sent += len + 1;
    end
  endtask

  // Output side: random stall bursts, plus one long hold on request.
  initial begin : out_pacing
    int quiet_left;
    bit hold_done;
    quiet_left   = 0;
    hold_done    = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet_left == 0) begin
        if (hold_out_req && !hold_done) begin
          hold_done  = 1'b1;
          quiet_left = LongHold;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
          quiet_left = $urandom_range(1, 6);
        end
      end
      if (quiet_left > 0) begin
        out_ch.ready <= 1'b0;
        quiet_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Ends the run when neither channel has moved a beat for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Main stimulus sequence.
  initial begin : stimulus
    logic [ShiftW-1:0] amount;
    rst_n             = 1'b0;
    shift_we          = 1'b0;
    shift_wdata       = '0;
    in_ch.valid       = 1'b0;
    in_ch.char_in     = '0;
    in_ch.end_of_text = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Opening sequence: letter extremes, every delimiter, dropped bytes and
    // the end-of-text cases.
    load_shift(5'd3);
    send_byte(CharA, 1'b0);
    send_byte(CharZ, 1'b0);
    send_byte(CharComma, 1'b0);
    send_byte(CharSpace, 1'b0);       // delimiter with nothing held
    send_byte(CharA, 1'b0);
    send_byte(CharPeriod, 1'b0);
    send_byte(CharZ, 1'b0);
    send_byte(CharQuest, 1'b0);
    send_byte(CharA, 1'b0);
    send_byte(CharNewline, 1'b0);
    send_byte(ByteLowA, 1'b0);
    send_byte(ByteMax, 1'b0);
    send_byte(ByteHigh, 1'b0);
    send_byte(ByteDigit, 1'b0);
    send_byte(ByteAt, 1'b0);
    send_byte(ByteBracket, 1'b0);
    send_byte(CharZ, 1'b1);           // end of text on a letter
    send_byte(CharA, 1'b0);
    send_byte(ByteLowZ, 1'b1);        // end of text on a dropped byte
    send_byte(CharZ, 1'b0);
    send_byte(CharSpace, 1'b1);       // end of text on a delimiter
    send_byte(ByteNul, 1'b1);         // end of text with nothing held
    send_byte(ByteDel, 1'b0);

    // Random phases over a range of shift settings; no idling in the last one.
    for (int p = 0; p < NumPhases; p++) begin
      amount = (p < 6) ? shift_plan[p] : ShiftW'($urandom_range(0, (1 << ShiftW) - 1));
      load_shift(amount);
      idle_en = (p == NumPhases - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      if (p == 2) hold_out_req = 1'b1;
      send_text(PhaseBeats);
    end

    // Overflow: one letter past a full word, then bytes that must give nothing.
    drain_block();
    for (int i = 0; i <= MaxWordDef; i++) send_byte(random_letter(), 1'b0);
    send_byte(random_letter(), 1'b0);
    send_byte(CharSpace, 1'b0);
    send_byte(CharZ, 1'b1);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (chars_owed == 0);
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/csw_pkg.sv
rtl/core/csw_in_if.sv
rtl/core/csw_out_if.sv
rtl/core/caesar_shift_word_reverser.sv
rtl/core/csw_checker.sv
sim/csw_scoreboard.sv
sim/caesar_shift_word_reverser_tb.sv
